// File: src/tlc_pkg.sv
// ----------------------------------------------------------------------------
// tlc_pkg
// Types and constants shared by the traffic light controller.
// ----------------------------------------------------------------------------
package tlc_pkg;

    localparam int HOLD_W      = 14;
    localparam int HOLD_COUNT  = 6;
    localparam int CFG_INDEX_W = 3;

    typedef enum logic [2:0] {
        PH_NS_ALL_RED = 3'd0,
        PH_NS_GREEN   = 3'd1,
        PH_NS_YELLOW  = 3'd2,
        PH_EW_ALL_RED = 3'd3,
        PH_EW_GREEN   = 3'd4,
        PH_EW_YELLOW  = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        MODE_PLAIN   = 2'd0,
        MODE_WALK    = 2'd1,
        MODE_CONFIG  = 2'd2,
        MODE_CAMERA  = 2'd3
    } mode_t;

    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_NS_ALL_RED = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_NS_GREEN   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_NS_YELLOW  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_EW_ALL_RED = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_EW_GREEN   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_EW_YELLOW  = 3'd5;

    localparam logic [HOLD_W-1:0] HOLD_RESET [HOLD_COUNT] = '{
        14'd500, 14'd6000, 14'd2000, 14'd500, 14'd6000, 14'd2000
    };

    localparam logic [7:0] LAMP_ALL_RED   = 8'h24;
    localparam logic [7:0] LAMP_NS_YELLOW = 8'h22;
    localparam logic [7:0] LAMP_NS_GREEN  = 8'h21;
    localparam logic [7:0] LAMP_EW_YELLOW = 8'h14;
    localparam logic [7:0] LAMP_EW_GREEN  = 8'h0C;
    localparam logic [7:0] LAMP_NS_WALK   = 8'h61;
    localparam logic [7:0] LAMP_EW_WALK   = 8'h8C;
    localparam logic [7:0] LAMP_FAULT     = 8'hFF;

    localparam logic [10:0] YELLOW_RUN_MS = 11'd2000;
    localparam logic [9:0]  MS_PER_SECOND = 10'd1000;
    localparam logic [15:0] SECONDS_MAX   = 16'hFFFF;

    localparam logic [2:0] EVT_NONE          = 3'd0;
    localparam logic [2:0] EVT_SNAPSHOT      = 3'd1;
    localparam logic [2:0] EVT_ARMED         = 3'd2;
    localparam logic [2:0] EVT_LEFT          = 3'd3;
    localparam logic [2:0] EVT_LEFT_RED_RUN  = 3'd4;

    typedef struct packed {
        logic       tick;
        logic       press_ns;
        logic       press_ew;
        logic       press_car;
        logic [1:0] mode_request;
    } tlc_item_t;

    typedef struct packed {
        logic [7:0]  lamps;
        logic [2:0]  phase;
        logic [1:0]  active_mode;
        logic [2:0]  camera_event;
        logic [15:0] dwell_seconds;
    } tlc_result_t;

endpackage

// File: src/traffic_light_controller_unit.sv
// ----------------------------------------------------------------------------
// traffic_light_controller_unit
// Six-phase two-road light controller with walk requests and red-light camera.
// ----------------------------------------------------------------------------
// Items are taken while item_stall is low; each result is registered in the
// result register, or in the skid register if a result waits untaken. An
// item's work is one pass of compare and counter logic from the controller
// state to the result registers, so the sustained rate is one item per cycle
// while results are taken. The two-entry buffer keeps intake running while a
// result waits; item_stall rises only when both entries are full. Hold times
// are set via the config port at any time and take effect on the next item.

module traffic_light_controller_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_stall,
    input  tlc_pkg::tlc_item_t                 item,
    output logic                               result_valid,
    input  logic                               result_stall,
    output tlc_pkg::tlc_result_t               result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tlc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tlc_pkg::HOLD_W-1:0]         cfg_data
);
    import tlc_pkg::*;

    logic [HOLD_W-1:0] hold_reg [HOLD_COUNT];

    phase_t            phase_reg, phase_next;
    mode_t             mode_reg, mode_next;
    logic              started_reg, started_next;
    logic [13:0]       phase_ms_reg, phase_ms_next;
    logic              walk_ns_reg, walk_ns_next;
    logic              walk_ew_reg, walk_ew_next;
    logic              walk_active_reg, walk_active_next;
    logic              car_inside_reg, car_inside_next;
    logic              car_leaving_reg, car_leaving_next;
    logic              camera_running_reg, camera_running_next;
    logic              yellow_armed_reg, yellow_armed_next;
    logic [10:0]       yellow_ms_reg, yellow_ms_next;
    logic              red_run_reg, red_run_next;
    logic [9:0]        second_ms_reg, second_ms_next;
    logic [15:0]       seconds_reg, seconds_next;

    logic [2:0]        event_code;
    logic [15:0]       dwell;
    logic [7:0]        lamps;
    tlc_result_t       new_result;

    logic              result_valid_reg, result_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    tlc_result_t       result_reg, result_next;
    tlc_result_t       skid_reg, skid_next;

    logic              accept;
    logic              take;

    assign cfg_ready    = 1'b1;
    assign item_stall   = skid_valid_reg;
    assign accept       = item_valid && !skid_valid_reg;
    assign take         = result_valid_reg && !result_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HOLD_COUNT; i++)
            begin
                hold_reg[i] <= HOLD_RESET[i];
            end
        end
        else if (cfg_valid && cfg_index < CFG_INDEX_W'(HOLD_COUNT))
        begin
            hold_reg[cfg_index] <= cfg_data;
        end
    end

    // next state for one item
    always_comb
    begin
        logic start_item;
        logic [HOLD_W-1:0] hold_cur;
        phase_t adv;

        phase_next          = phase_reg;
        mode_next           = mode_reg;
        started_next        = started_reg;
        phase_ms_next       = phase_ms_reg;
        walk_ns_next        = walk_ns_reg;
        walk_ew_next        = walk_ew_reg;
        walk_active_next    = walk_active_reg;
        car_inside_next     = car_inside_reg;
        car_leaving_next    = car_leaving_reg;
        camera_running_next = camera_running_reg;
        yellow_armed_next   = yellow_armed_reg;
        yellow_ms_next      = yellow_ms_reg;
        red_run_next        = red_run_reg;
        second_ms_next      = second_ms_reg;
        seconds_next        = seconds_reg;
        event_code          = EVT_NONE;
        start_item          = 1'b0;
        hold_cur            = hold_reg[0];
        adv                 = PH_NS_ALL_RED;

        if (mode_t'(item.mode_request) != mode_next &&
            (phase_next == PH_NS_ALL_RED || phase_next == PH_EW_ALL_RED))
        begin
            phase_next          = PH_NS_ALL_RED;
            started_next        = 1'b0;
            mode_next           = mode_t'(item.mode_request);
            camera_running_next = 1'b0;
            yellow_armed_next   = 1'b0;
        end

        if (!started_next)
        begin
            start_item    = 1'b1;
            started_next  = 1'b1;
            phase_ms_next = '0;
            if (mode_next != MODE_PLAIN)
            begin
                walk_ns_next     = 1'b0;
                walk_ew_next     = 1'b0;
                walk_active_next = 1'b0;
                car_inside_next  = 1'b0;
                car_leaving_next = 1'b0;
            end
        end

        if (item.press_ns)
        begin
            walk_ns_next = 1'b1;
        end
        if (item.press_ew)
        begin
            walk_ew_next = 1'b1;
        end
        if (item.press_car)
        begin
            if (!car_inside_next)
            begin
                car_inside_next = 1'b1;
            end
            else
            begin
                car_leaving_next = 1'b1;
            end
        end

        if (item.tick && yellow_armed_next)
        begin
            yellow_ms_next = yellow_ms_next + 11'd1;
            if (yellow_ms_next >= YELLOW_RUN_MS)
            begin
                red_run_next      = 1'b1;
                yellow_armed_next = 1'b0;
            end
        end
        if (item.tick && camera_running_next)
        begin
            second_ms_next = second_ms_next + 10'd1;
            if (second_ms_next >= MS_PER_SECOND)
            begin
                second_ms_next = '0;
                if (seconds_next != SECONDS_MAX)
                begin
                    seconds_next = seconds_next + 16'd1;
                end
            end
        end

        if (mode_next == MODE_CAMERA)
        begin
            if (!camera_running_next && car_inside_next)
            begin
                red_run_next      = 1'b0;
                yellow_armed_next = 1'b0;
                if (phase_next == PH_NS_ALL_RED || phase_next == PH_EW_ALL_RED)
                begin
                    event_code = EVT_SNAPSHOT;
                end
                else if (phase_next == PH_NS_YELLOW || phase_next == PH_EW_YELLOW)
                begin
                    yellow_armed_next = 1'b1;
                    yellow_ms_next    = '0;
                    event_code        = EVT_ARMED;
                end
                seconds_next        = '0;
                second_ms_next      = '0;
                camera_running_next = 1'b1;
            end
            if (car_inside_next && car_leaving_next)
            begin
                car_inside_next     = 1'b0;
                car_leaving_next    = 1'b0;
                camera_running_next = 1'b0;
                event_code          = red_run_next ? EVT_LEFT_RED_RUN : EVT_LEFT;
            end
        end
        dwell = seconds_next;

        if (item.tick && !start_item)
        begin
            unique case (phase_next)
                PH_NS_ALL_RED: begin hold_cur = hold_reg[0]; adv = PH_NS_GREEN;   end
                PH_NS_GREEN:   begin hold_cur = hold_reg[1]; adv = PH_NS_YELLOW;  end
                PH_NS_YELLOW:  begin hold_cur = hold_reg[2]; adv = PH_EW_ALL_RED; end
                PH_EW_ALL_RED: begin hold_cur = hold_reg[3]; adv = PH_EW_GREEN;   end
                PH_EW_GREEN:   begin hold_cur = hold_reg[4]; adv = PH_EW_YELLOW;  end
                PH_EW_YELLOW:  begin hold_cur = hold_reg[5]; adv = PH_NS_ALL_RED; end
                default:       begin hold_cur = hold_reg[0]; adv = PH_NS_GREEN;   end
            endcase
            phase_ms_next = phase_ms_next + 14'd1;
            if (phase_ms_next >= hold_cur)
            begin
                phase_next    = adv;
                phase_ms_next = '0;
                if (mode_next != MODE_PLAIN)
                begin
                    unique case (adv)
                        PH_NS_ALL_RED:
                        begin
                            if (walk_ns_next)
                            begin
                                walk_active_next = 1'b1;
                            end
                        end
                        PH_NS_YELLOW:
                        begin
                            if (walk_active_next)
                            begin
                                walk_ns_next = 1'b0;
                            end
                            walk_active_next = 1'b0;
                        end
                        PH_EW_ALL_RED:
                        begin
                            if (walk_ew_next)
                            begin
                                walk_active_next = 1'b1;
                            end
                        end
                        PH_EW_YELLOW:
                        begin
                            if (walk_active_next)
                            begin
                                walk_ew_next = 1'b0;
                            end
                            walk_active_next = 1'b0;
                        end
                        default:
                        begin
                            walk_active_next = walk_active_next;
                        end
                    endcase
                end
            end
        end
    end

    // lamp decode from the post-item state
    always_comb
    begin
        logic walk;
        walk = walk_active_next && mode_next != MODE_PLAIN;
        unique case (phase_next)
            PH_NS_ALL_RED: lamps = LAMP_ALL_RED;
            PH_NS_GREEN:   lamps = walk ? LAMP_NS_WALK : LAMP_NS_GREEN;
            PH_NS_YELLOW:  lamps = LAMP_NS_YELLOW;
            PH_EW_ALL_RED: lamps = LAMP_ALL_RED;
            PH_EW_GREEN:   lamps = walk ? LAMP_EW_WALK : LAMP_EW_GREEN;
            PH_EW_YELLOW:  lamps = LAMP_EW_YELLOW;
            default:       lamps = LAMP_FAULT;
        endcase
    end

    always_comb
    begin
        new_result.lamps         = lamps;
        new_result.phase         = phase_next;
        new_result.active_mode   = mode_next;
        new_result.camera_event  = event_code;
        new_result.dwell_seconds = dwell;
    end

    // two-entry result buffer
    always_comb
    begin
        result_valid_next = result_valid_reg;
        skid_valid_next   = skid_valid_reg;
        result_next       = result_reg;
        skid_next         = skid_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                result_next     = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (!result_valid_reg || take)
            begin
                result_next       = new_result;
                result_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = new_result;
                skid_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        skid_reg   <= skid_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg   <= 1'b0;
            skid_valid_reg     <= 1'b0;
            phase_reg          <= PH_NS_ALL_RED;
            mode_reg           <= MODE_PLAIN;
            started_reg        <= 1'b0;
            phase_ms_reg       <= '0;
            walk_ns_reg        <= 1'b0;
            walk_ew_reg        <= 1'b0;
            walk_active_reg    <= 1'b0;
            car_inside_reg     <= 1'b0;
            car_leaving_reg    <= 1'b0;
            camera_running_reg <= 1'b0;
            yellow_armed_reg   <= 1'b0;
            yellow_ms_reg      <= '0;
            red_run_reg        <= 1'b0;
            second_ms_reg      <= '0;
            seconds_reg        <= '0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            skid_valid_reg   <= skid_valid_next;
            if (accept)
            begin
                phase_reg          <= phase_next;
                mode_reg           <= mode_next;
                started_reg        <= started_next;
                phase_ms_reg       <= phase_ms_next;
                walk_ns_reg        <= walk_ns_next;
                walk_ew_reg        <= walk_ew_next;
                walk_active_reg    <= walk_active_next;
                car_inside_reg     <= car_inside_next;
                car_leaving_reg    <= car_leaving_next;
                camera_running_reg <= camera_running_next;
                yellow_armed_reg   <= yellow_armed_next;
                yellow_ms_reg      <= yellow_ms_next;
                red_run_reg        <= red_run_next;
                second_ms_reg      <= second_ms_next;
                seconds_reg        <= seconds_next;
            end
        end
    end

    a_skid_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> result_valid_reg)
        else $error("skid entry held with empty result register");

    a_mode_change_all_red: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg != $past(mode_reg)) |->
        ($past(phase_reg) == PH_NS_ALL_RED || $past(phase_reg) == PH_EW_ALL_RED))
        else $error("mode changed outside an all-red phase");

    a_camera_mode_only: assert property (@(posedge clk) disable iff (!rst_n)
        (camera_running_reg || yellow_armed_reg) |-> mode_reg == MODE_CAMERA)
        else $error("camera counters running outside camera mode");

endmodule
